// ----- design/sslc_pkg.sv -----
// ---------------------------------------------------------------------------
// sslc_pkg
// Codes and helpers shared by the shutter switch lock control.
// ---------------------------------------------------------------------------
package sslc_pkg;

  // switch positions
  localparam logic [1:0] POS_LOCKED  = 2'd0;
  localparam logic [1:0] POS_UP      = 2'd1;
  localparam logic [1:0] POS_DOWN    = 2'd2;
  localparam logic [1:0] POS_NEUTRAL = 2'd3;

  // shutter commands
  localparam logic [1:0] CMD_OFF  = 2'd0;
  localparam logic [1:0] CMD_UP   = 2'd1;
  localparam logic [1:0] CMD_DOWN = 2'd2;

  // item actions
  localparam logic ACT_CLEAR  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  // configuration register indexes
  localparam logic REG_HOLD = 1'b0;
  localparam logic REG_RUN  = 1'b1;

  localparam logic [31:0] HOLD_RESET = 32'd2000;   // 2 s
  localparam logic [31:0] RUN_RESET  = 32'd60000;  // 60 s

  localparam logic [2:0] CODE_MASK = 3'h7;
  localparam logic [3:0] CHAN_MASK = 4'hf;

  // command byte: (cmd+1)<<4 | channel, bit 7 makes the byte even parity
  function automatic logic [7:0] frame_of(input logic [1:0] cmd, input logic [1:0] ch);
    logic [2:0] code;
    logic [6:0] low;
    code = (3'({1'b0, cmd}) + 3'd1) & CODE_MASK;
    low  = {code, 4'({2'b00, ch}) & CHAN_MASK};
    return {^low, low};
  endfunction

endpackage

// ----- design/shutter_switch_lock_control.sv -----
// ---------------------------------------------------------------------------
// shutter_switch_lock_control
// Per-channel switch lock logic issuing shutter commands and lock beeps.
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while the output is not stalled; a stalled
// output with an item held in stage 1 stalls the input. The result passes
// from the stage 1 register into the output register. The per-channel memory
// is read-modify-write: the entry is read at input transfer, the decision is
// made in stage 1 and written back as the item leaves it, and a write to the
// entry that the next item reads is forwarded to it. For a clear item the
// per-channel valid bits are dropped and the clear time is kept in one
// register, so an entry not written since reads as neutral stamped with that
// time. Exactly one result per item; results other than a command carry zero
// in the command fields.
module shutter_switch_lock_control
  import sslc_pkg::*;
#(
  parameter int CHANNELS  = 4,
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [1:0]  channel,
  input  logic [1:0]  switch_pos,
  input  logic [31:0] now_ms,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        drive_valid,
  output logic [1:0]  drive_cmd,
  output logic [1:0]  drive_channel,
  output logic [7:0]  frame_byte,
  output logic        lock_beep
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CW = (TIME_BITS > 32) ? TIME_BITS : 32;   // compare width
  localparam int EW = 2 + TIME_BITS;                        // entry width

  typedef logic [TIME_BITS-1:0] stamp_t;

  // configuration registers
  logic [31:0] hold_delay_ms;
  logic [31:0] run_delay_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_delay_ms <= HOLD_RESET;
      run_delay_ms  <= RUN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HOLD: hold_delay_ms <= cfg_data;
        REG_RUN:  run_delay_ms  <= cfg_data;
        default:  ;
      endcase
    end
  end

  // ---- handshake -----------------------------------------------------------
  logic in_xfer;
  logic s1_valid;
  logic s1_go;      // stage 1 result moves into the output register
  logic out_free;

  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  // ---- stage 0 -> 1 --------------------------------------------------------
  logic [AW-1:0] in_addr;
  logic          in_range;
  assign in_addr  = AW'(channel);
  assign in_range = (32'(channel) < CHANNELS);

  logic          s1_action;
  logic [1:0]    s1_channel;
  logic [1:0]    s1_pos;
  stamp_t        s1_now;
  logic [AW-1:0] s1_addr;
  logic          s1_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action  <= action;
      s1_channel <= channel;
      s1_pos     <= switch_pos;
      s1_now     <= TIME_BITS'(now_ms);
      s1_addr    <= in_addr;
      s1_range   <= in_range;
    end
  end

  // ---- channel memory: {position, last change time} ------------------------
  logic [EW-1:0] mem [CHANNELS];
  logic [EW-1:0] rd_q;
  logic          wr_en;
  logic [1:0]    wr_pos;
  logic [EW-1:0] wr_data;

  assign wr_data = {wr_pos, s1_now};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_addr] <= wr_data;
    end
    if (in_xfer) begin
      rd_q <= mem[in_addr];
    end
  end

  // forwarding of a write that lands on the edge the next item reads
  logic          fwd_hit;
  logic [EW-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_xfer) begin
      fwd_hit <= wr_en && (s1_addr == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      fwd_data <= wr_data;
    end
  end

  // entry valid bits and the time of the last clear
  logic [CHANNELS-1:0] valid;
  stamp_t              clear_time;
  logic                clr_en;

  assign clr_en = s1_go && (s1_action == ACT_CLEAR);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      clear_time <= '0;
    end else if (clr_en) begin
      valid      <= '0;
      clear_time <= s1_now;
    end else if (wr_en) begin
      valid[s1_addr] <= 1'b1;
    end
  end

  // ---- stage 1: decision ---------------------------------------------------
  logic [EW-1:0] raw_entry;
  logic [1:0]    old_pos;
  stamp_t        old_time;
  stamp_t        elapsed;
  logic [CW-1:0] el_ext;
  logic          over_hold;
  logic          under_run;
  logic          changed;
  logic          ignore;
  logic          beep;
  logic          issue;
  logic [1:0]    cmd;
  logic          sample_ok;

  assign raw_entry = fwd_hit ? fwd_data : rd_q;

  always_comb begin
    if (s1_range && valid[s1_addr]) begin
      old_pos  = raw_entry[EW-1 -: 2];
      old_time = raw_entry[TIME_BITS-1:0];
    end else begin
      old_pos  = POS_NEUTRAL;
      old_time = clear_time;
    end
  end

  assign elapsed   = s1_now - old_time;
  assign el_ext    = CW'(elapsed);
  assign over_hold = el_ext > CW'(hold_delay_ms);
  assign under_run = el_ext < CW'(run_delay_ms);
  assign sample_ok = (s1_action == ACT_SAMPLE) && s1_range;

  // lock rules while the run delay has not gone by
  assign ignore = under_run && over_hold && (s1_pos == POS_NEUTRAL);
  assign beep   = under_run && over_hold && (s1_pos != POS_NEUTRAL) && (s1_pos == old_pos);
  assign changed = (s1_pos != old_pos) && !ignore && !beep;

  always_comb begin
    issue  = 1'b0;
    cmd    = CMD_OFF;
    wr_pos = s1_pos;
    if (changed && (old_pos != POS_LOCKED)) begin
      if (over_hold) begin
        // held long: stop and fall back to neutral
        issue  = 1'b1;
        wr_pos = POS_NEUTRAL;
      end else begin
        unique case (s1_pos)
          POS_NEUTRAL: issue = 1'b1;
          POS_UP: begin
            issue = 1'b1;
            cmd   = CMD_UP;
          end
          POS_DOWN: begin
            issue = 1'b1;
            cmd   = CMD_DOWN;
          end
          default: ;   // locked reading within hold: stored only
        endcase
      end
    end
  end

  assign wr_en = s1_go && sample_ok && changed;

  // ---- output register -----------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      drive_valid   <= sample_ok && issue;
      drive_cmd     <= (sample_ok && issue) ? cmd : CMD_OFF;
      drive_channel <= (sample_ok && issue) ? s1_channel : 2'd0;
      frame_byte    <= (sample_ok && issue) ? frame_of(cmd, s1_channel) : 8'd0;
      lock_beep     <= sample_ok && beep;
    end
  end

  // ---- assertions ----------------------------------------------------------
  // a forwarded entry was written when its item entered stage 1, so it is valid
  a_fwd_valid: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && fwd_hit && s1_range) |-> valid[s1_addr])
    else $error("forwarded entry has no valid bit");

  // a write-back marks its entry valid on the next edge
  a_wr_marks: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> valid[$past(s1_addr)])
    else $error("written entry not marked valid");

  // a command and a beep never come from the same item
  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(drive_valid && lock_beep))
    else $error("command and beep in one result");

  // without a command the command fields stay zero
  a_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !drive_valid) |-> (frame_byte == 8'd0 && drive_cmd == CMD_OFF))
    else $error("command fields set without a command");

endmodule

// ----- tb/sslc_drive_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// sslc_drive_checker
// Watches both channels of the shutter switch lock control, predicts the
// result of each input transfer and compares the output transfers in order.
// ---------------------------------------------------------------------------
module sslc_drive_checker
  import sslc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        action,
  input  logic [1:0]  channel,
  input  logic [1:0]  switch_pos,
  input  logic [31:0] now_ms,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        drive_valid,
  input  logic [1:0]  drive_cmd,
  input  logic [1:0]  drive_channel,
  input  logic [7:0]  frame_byte,
  input  logic        lock_beep,
  output int          mismatches,
  output int          outstanding,
  output int          commands,
  output int          beeps
);

  typedef struct packed {
    logic       valid;
    logic [1:0] cmd;
    logic [1:0] ch;
    logic [7:0] frame;
    logic       beep;
  } drive_t;

  logic [1:0]  saved_pos    [4];
  logic [31:0] change_stamp [4];
  logic [31:0] hold_ms;
  logic [31:0] run_ms;
  drive_t      drive_expect_q [$];

  // updates the channel table and returns the result the item should give
  function automatic drive_t next_drive(input logic act, input logic [1:0] ch,
                                        input logic [1:0] pos, input logic [31:0] now);
    drive_t      r;
    logic [31:0] elapsed;
    logic [1:0]  was;
    logic [6:0]  low;
    r = '0;
    if (act == ACT_CLEAR) begin
      foreach (saved_pos[i]) begin
        saved_pos[i]    = POS_NEUTRAL;
        change_stamp[i] = now;
      end
      return r;
    end
    elapsed = now - change_stamp[ch];
    if (elapsed < run_ms) begin
      if (pos == POS_NEUTRAL && elapsed > hold_ms) return r;
      if (pos != POS_NEUTRAL && pos == saved_pos[ch] && elapsed > hold_ms) begin
        r.beep = 1'b1;
        return r;
      end
    end
    if (pos == saved_pos[ch]) return r;
    was             = saved_pos[ch];
    saved_pos[ch]    = pos;
    change_stamp[ch] = now;
    if (was == POS_LOCKED) return r;
    if (elapsed > hold_ms) begin
      r.valid       = 1'b1;
      r.cmd         = CMD_OFF;
      saved_pos[ch] = POS_NEUTRAL;
    end else begin
      case (pos)
        POS_NEUTRAL: begin r.valid = 1'b1; r.cmd = CMD_OFF;  end
        POS_UP:      begin r.valid = 1'b1; r.cmd = CMD_UP;   end
        POS_DOWN:    begin r.valid = 1'b1; r.cmd = CMD_DOWN; end
        default: ;
      endcase
    end
    if (r.valid) begin
      r.ch    = ch;
      low     = {{1'b0, r.cmd} + 3'd1, 2'b00, ch};
      r.frame = {^low, low};
    end
    return r;
  endfunction

  always @(posedge clk) begin
    drive_t seen;
    drive_t want;
    if (rst) begin
      foreach (saved_pos[i]) begin
        saved_pos[i]    = POS_NEUTRAL;
        change_stamp[i] = '0;
      end
      hold_ms = HOLD_RESET;
      run_ms  = RUN_RESET;
      drive_expect_q.delete();
      mismatches <= 0;
      commands   <= 0;
      beeps      <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HOLD) hold_ms = cfg_data;
        else                       run_ms  = cfg_data;
      end
      // compare before predicting: a result leaving now belongs to an older transfer
      if (out_valid && !out_stall) begin
        seen = {drive_valid, drive_cmd, drive_channel, frame_byte, lock_beep};
        if (drive_valid === 1'b1) commands <= commands + 1;
        if (lock_beep === 1'b1)   beeps    <= beeps + 1;
        if (drive_expect_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result transfer with nothing expected: %s%0b %0d %0d %02h %0b",
                     $realtime, "valid/cmd/ch/frame/beep=",
                     seen.valid, seen.cmd, seen.ch, seen.frame, seen.beep);
          mismatches <= mismatches + 1;
        end else begin
          want = drive_expect_q.pop_front();
          if (seen.valid !== want.valid || seen.cmd !== want.cmd || seen.ch !== want.ch ||
              seen.frame !== want.frame || seen.beep !== want.beep) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch, expected valid=%0b cmd=%0d ch=%0d frame=%02h beep=%0b",
                       $realtime, want.valid, want.cmd, want.ch, want.frame, want.beep);
              $display("%0t:           actual valid=%0b cmd=%0d ch=%0d frame=%02h beep=%0b",
                       $realtime, seen.valid, seen.cmd, seen.ch, seen.frame, seen.beep);
            end
            mismatches <= mismatches + 1;
          end
        end
      end
      if (in_valid && !in_stall)
        drive_expect_q.push_back(next_drive(action, channel, switch_pos, now_ms));
    end
    outstanding <= drive_expect_q.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Regression for the shutter switch lock control: directed switch sequences,
// then randomised press/hold/release gestures over several delay settings,
// with bursty input, random output stalls and a checker module alongside.
// ---------------------------------------------------------------------------
module tb_top;
  import sslc_pkg::*;

  localparam int LIMIT_CYCLES = 200000;  // far above the slowest legal run
  localparam int PHASE_ITEMS  = 85;      // seven random phases, ~600 items
  localparam int CHOKE_CYCLES = 150;     // long receiver hold-off

  // stimulus side
  logic        clk        = 1'b0;
  logic        rst        = 1'b1;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = REG_HOLD;
  logic [31:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  logic        action     = ACT_SAMPLE;
  logic [1:0]  channel    = '0;
  logic [1:0]  switch_pos = POS_NEUTRAL;
  logic [31:0] now_ms     = '0;
  logic        out_stall  = 1'b0;

  // block outputs
  logic        in_stall;
  logic        out_valid;
  logic        drive_valid;
  logic [1:0]  drive_cmd;
  logic [1:0]  drive_channel;
  logic [7:0]  frame_byte;
  logic        lock_beep;

  // checker status
  int mismatches;
  int outstanding;
  int commands;
  int beeps;

  // current delay settings, used only to aim times at the thresholds
  logic [31:0] hold_cur = HOLD_RESET;
  logic [31:0] run_cur  = RUN_RESET;
  logic [31:0] last_seen [4];   // time of the last transfer per channel

  int   burst_left = 0;
  int   sent       = 0;
  int   settings   = 1;
  int   cycles     = 0;
  int   choke_reqs = 0;         // long hold-offs asked for by the sender
  int   choke_done = 0;         // hold-offs the receiver has taken up
  int   choke_left = 0;

  shutter_switch_lock_control i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .channel      (channel),
    .switch_pos   (switch_pos),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_valid  (drive_valid),
    .drive_cmd    (drive_cmd),
    .drive_channel(drive_channel),
    .frame_byte   (frame_byte),
    .lock_beep    (lock_beep)
  );

  sslc_drive_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .channel      (channel),
    .switch_pos   (switch_pos),
    .now_ms       (now_ms),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .drive_valid  (drive_valid),
    .drive_cmd    (drive_cmd),
    .drive_channel(drive_channel),
    .frame_byte   (frame_byte),
    .lock_beep    (lock_beep),
    .mismatches   (mismatches),
    .outstanding  (outstanding),
    .commands     (commands),
    .beeps        (beeps)
  );

  always #10 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("shutter_switch_lock_control regression: fail");
      $finish;
    end
  end

  // Receiver: stall pattern switches mode at random intervals (free flow,
  // light, heavy, alternating). A hold-off request overrides it for a long
  // stretch so the block backs up and stalls its input.
  int stall_mode = 0;
  int mode_left  = 0;
  always @(negedge clk) begin
    if (choke_reqs != choke_done) begin
      choke_done = choke_reqs;
      choke_left = CHOKE_CYCLES;
    end
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(8, 64);
    end
    mode_left--;
    if (choke_left > 0) begin
      choke_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  // one input transfer; bursts of random length with random gaps between
  task automatic put(input logic act, input logic [1:0] ch, input logic [1:0] pos,
                     input logic [31:0] t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (choke_reqs != choke_done || choke_left > 0) gap = 0;  // keep pushing while held off
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    action     <= act;
    channel    <= ch;
    switch_pos <= pos;
    now_ms     <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    sent++;
    if (act == ACT_CLEAR) begin
      foreach (last_seen[i]) last_seen[i] = t;
    end else begin
      last_seen[ch] = t;
    end
  endtask

  // stop offering and wait for every outstanding result, plus pipeline slack
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_HOLD) hold_cur = val;
    else                 run_cur  = val;
  endtask

  // time for the next sample on a channel, mostly right on a threshold
  function automatic logic [31:0] pick_now(input logic [1:0] ch);
    logic [31:0] d;
    case ($urandom_range(0, 9))
      0:       d = '0;
      1:       d = hold_cur;
      2:       d = hold_cur + 1;
      3:       d = hold_cur - 1;
      4:       d = run_cur - 1;
      5:       d = run_cur;
      6:       d = run_cur + 1;
      7:       d = $urandom_range(0, 3);
      8:       d = $urandom;
      default: d = (hold_cur >> 1) + $urandom_range(0, 16);
    endcase
    return last_seen[ch] + d;
  endfunction

  function automatic logic [1:0] pick_pos();
    case ($urandom_range(0, 9))
      0, 1, 2: return POS_UP;
      3, 4, 5: return POS_DOWN;
      6, 7, 8: return POS_NEUTRAL;
      default: return POS_LOCKED;
    endcase
  endfunction

  // press, hold until locked, then release / reverse / lock the switch
  task automatic gesture();
    logic [1:0] ch;
    logic [1:0] dir;
    ch  = $urandom_range(0, 3);
    dir = $urandom_range(0, 1) ? POS_UP : POS_DOWN;
    put(ACT_SAMPLE, ch, dir, last_seen[ch] + $urandom_range(0, 1));
    put(ACT_SAMPLE, ch, dir, last_seen[ch] + hold_cur + 1);
    case ($urandom_range(0, 2))
      0:       put(ACT_SAMPLE, ch, POS_NEUTRAL, pick_now(ch));
      1:       put(ACT_SAMPLE, ch, (dir == POS_UP) ? POS_DOWN : POS_UP, pick_now(ch));
      default: put(ACT_SAMPLE, ch, pick_pos(), pick_now(ch));
    endcase
  endtask

  task automatic run_phase(input int items);
    int target;
    logic [1:0] ch;
    target = sent + items;
    while (sent < target) begin
      if ($urandom_range(0, 9) < 6) begin
        gesture();
      end else begin
        ch = $urandom_range(0, 3);
        if ($urandom_range(0, 24) == 0)
          put(ACT_CLEAR, ch, pick_pos(), $urandom);
        else
          put(ACT_SAMPLE, ch, pick_pos(), pick_now(ch));
      end
    end
  endtask

  // Directed opening with reset delays (hold 2 s, run 60 s): plain moves,
  // lock and beep, neutral ignored after the hold, long hold forcing off,
  // locked reading stored silently, move away from locked, run delay edge,
  // clears and time wrap-around.
  task automatic directed();
    put(ACT_SAMPLE, 2'd0, POS_UP,      32'd100);
    put(ACT_SAMPLE, 2'd0, POS_UP,      32'd2101);
    put(ACT_SAMPLE, 2'd0, POS_UP,      32'd2100);        // exactly the hold
    put(ACT_SAMPLE, 2'd0, POS_NEUTRAL, 32'd2101);
    put(ACT_SAMPLE, 2'd0, POS_NEUTRAL, 32'd2099);
    put(ACT_SAMPLE, 2'd1, POS_DOWN,    32'd500);
    put(ACT_SAMPLE, 2'd1, POS_UP,      32'd3500);
    put(ACT_SAMPLE, 2'd2, POS_LOCKED,  32'd10);
    put(ACT_SAMPLE, 2'd2, POS_LOCKED,  32'd5000);
    put(ACT_SAMPLE, 2'd2, POS_UP,      32'd5010);
    put(ACT_SAMPLE, 2'd2, POS_NEUTRAL, 32'd5020);
    put(ACT_SAMPLE, 2'd3, POS_UP,      32'd60000);       // exactly the run delay
    put(ACT_SAMPLE, 2'd3, POS_DOWN,    32'd119999);
    put(ACT_SAMPLE, 2'd3, POS_NEUTRAL, 32'd189999);
    put(ACT_CLEAR,  2'd3, POS_LOCKED,  32'hFFFF_FFF0);
    put(ACT_SAMPLE, 2'd0, POS_DOWN,    32'h0000_0010);   // wraps past zero
    put(ACT_SAMPLE, 2'd1, POS_UP,      32'hFFFF_FFF0);
    put(ACT_SAMPLE, 2'd3, POS_LOCKED,  32'hFFFF_FFFF);
    put(ACT_CLEAR,  2'd0, POS_UP,      32'h0000_0000);
    put(ACT_SAMPLE, 2'd1, POS_DOWN,    32'hFFFF_FFFF);
    put(ACT_SAMPLE, 2'd2, POS_NEUTRAL, 32'h7FFF_FFFF);
    put(ACT_SAMPLE, 2'd3, POS_DOWN,    32'h0000_0001);
    put(ACT_SAMPLE, 2'd3, POS_UP,      32'h0000_0002);
    put(ACT_SAMPLE, 2'd3, POS_UP,      32'd2003);
  endtask

  logic [31:0] hold_tab [6];
  logic [31:0] run_tab  [6];

  initial begin
    foreach (last_seen[i]) last_seen[i] = '0;
    // extremes first, then hold below and above run, then random settings
    hold_tab = '{32'd0, 32'hFFFF_FFFF, 32'd5,  32'd20, 32'd0, 32'd0};
    run_tab  = '{32'd0, 32'hFFFF_FFFF, 32'd20, 32'd5,  32'd0, 32'd0};
    hold_tab[4] = $urandom_range(0, 40);
    run_tab[4]  = $urandom_range(0, 120);
    hold_tab[5] = $urandom;
    run_tab[5]  = $urandom;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    directed();
    settle();
    run_phase(PHASE_ITEMS);
    settle();

    for (int k = 0; k < 6; k++) begin
      write_reg(REG_HOLD, hold_tab[k]);
      write_reg(REG_RUN, run_tab[k]);
      settings++;
      run_phase(PHASE_ITEMS / 2);
      if (k == 2) choke_reqs++;       // long output hold-off while still sending
      if (k == 3) settle();           // sender drains the block mid-phase
      run_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
      settle();
    end

    $display("covered %0d transfers over %0d delay settings (extremes, hold above run, random)",
             sent, settings);
    $display("observed %0d shutter commands and %0d lock beeps, %0d mismatches",
             commands, beeps, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("shutter_switch_lock_control regression: pass");
    end else begin
      $display("shutter_switch_lock_control regression: fail");
    end
    $finish;
  end

endmodule
